[rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
// both sample on clk and are disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define CCBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication check
`define CCBP_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

[rtl/ccbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbp_pkg
// Shared widths, constants and types of the color code boundary path block.
// ----------------------------------------------------------------------------
package ccbp_pkg;

  localparam int CHECK_W   = 11;  // check index width
  localparam int PLAQ_W    = 10;  // plaquette number width
  localparam int DATA_W    = 12;  // data qubit index width
  localparam int CFG_W     = 6;   // rows register width
  localparam int ROW_W     = 6;   // row, column and row count width
  localparam int CNT_W     = 7;   // result count width
  localparam int TRI_W     = 11;  // triangular number width

  // divide by 3 as multiply by ceil(2^13 / 3), exact for 11-bit inputs
  localparam int RECIP3    = 2731;
  localparam int RECIP_W   = 12;
  localparam int RECIP_SH  = 13;

  localparam logic [CFG_W-1:0] ROWS_RESET = 6'd3;

  typedef enum logic [1:0] {
    COLOR_DOWN  = 2'd0,
    COLOR_LEFT  = 2'd1,
    COLOR_RIGHT = 2'd2
  } color_t;

  // decoded check handed from the root unit to the path sequencer
  typedef struct packed {
    logic             start;
    logic             err;
    color_t           color;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [ROW_W-1:0] nrows;
  } job_t;

  typedef struct packed {
    logic idle;
  } path_status_t;

endpackage

[rtl/ccbp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbp_if
// Valid/ready channel interfaces for check, result and configuration.
// ----------------------------------------------------------------------------
interface ccbp_in_if import ccbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHECK_W-1:0] check_index;

  modport source (output valid, output check_index, input ready);
  modport sink   (input valid, input check_index, output ready);
endinterface

interface ccbp_out_if import ccbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_index;
  logic              last;
  logic              index_error;

  modport source (output valid, output data_index, output last, output index_error,
                  input ready);
  modport sink   (input valid, input data_index, input last, input index_error,
                  output ready);
endinterface

interface ccbp_cfg_if import ccbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/ccbp_root.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbp_root
// Splits a check index into color and plaquette, then finds the plaquette
// row by a serial triangular root search, one add and compare per cycle.
// ----------------------------------------------------------------------------
module ccbp_root import ccbp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [ROW_W-1:0] nrows,
  input  path_status_t     path_status,
  ccbp_in_if.sink          check,
  output job_t             job
);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_DIV  = 3'b010,
    R_ROOT = 3'b100
  } root_state_t;

  root_state_t state;

  logic [CHECK_W-1:0]         chk;
  logic [PLAQ_W-1:0]          plaq;
  logic [ROW_W-1:0]           r;
  logic [TRI_W-1:0]           tri_hi;  // (r+1)(r+2)/2
  logic [TRI_W-1:0]           tri_lo;  // r(r+1)/2

  logic [CHECK_W+RECIP_W-1:0] prod;
  logic [CHECK_W-1:0]         three_plaq;
  logic [CHECK_W-1:0]         rem;
  logic                       tri_le;
  logic [TRI_W-1:0]           tri_add;
  logic [PLAQ_W-1:0]          col_full;

  assign prod       = chk * RECIP_W'(RECIP3);
  assign three_plaq = CHECK_W'({plaq, 1'b0}) + CHECK_W'(plaq);
  assign rem        = chk - three_plaq;
  assign tri_le     = tri_hi <= TRI_W'(plaq);
  assign tri_add    = tri_hi + TRI_W'(r) + TRI_W'(2);
  assign col_full   = plaq - tri_lo[PLAQ_W-1:0];

  // hold off while a finished job is still on its way to the path unit
  assign check.ready = (state == R_IDLE) && path_status.idle && !job.start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= R_IDLE;
      job.start <= 1'b0;
    end else begin
      job.start <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (check.valid && check.ready) begin
            chk   <= check.check_index;
            state <= R_DIV;
          end
        end
        R_DIV: begin
          plaq   <= prod[RECIP_SH +: PLAQ_W];
          r      <= '0;
          tri_hi <= TRI_W'(1);
          tri_lo <= '0;
          state  <= R_ROOT;
        end
        R_ROOT: begin
          if (r == nrows) begin
            // row beyond the lattice
            job.start <= 1'b1;
            job.err   <= 1'b1;
            job.color <= color_t'(rem[1:0]);
            job.row   <= r;
            job.col   <= '0;
            job.nrows <= nrows;
            state     <= R_IDLE;
          end else if (tri_le) begin
            r      <= r + ROW_W'(1);
            tri_lo <= tri_hi;
            tri_hi <= tri_add;
          end else begin
            job.start <= 1'b1;
            job.err   <= 1'b0;
            job.color <= color_t'(rem[1:0]);
            job.row   <= r;
            job.col   <= col_full[ROW_W-1:0];
            job.nrows <= nrows;
            state     <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

[rtl/ccbp_path.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbp_path
// Sets up the first data qubit index of the walk, then steps one shared
// adder per result into a registered output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccbp_path import ccbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  job_t         job,
  output path_status_t status,
  ccbp_out_if.source   result
);

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_SQ   = 4'b0010,
    P_INIT = 4'b0100,
    P_EMIT = 4'b1000
  } path_state_t;

  path_state_t state;

  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  col;
  logic [ROW_W-1:0]  nrows;
  color_t            color;
  logic [DATA_W-1:0] sq;
  logic [DATA_W-1:0] acc;
  logic [CNT_W-1:0]  remaining;
  logic [ROW_W-1:0]  kk;
  logic              phase;
  logic              err_flag;

  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  logic              out_last;
  logic              out_err;

  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] two_c;
  logic [DATA_W-1:0] init_acc;
  logic [CNT_W-1:0]  init_cnt;
  logic [DATA_W-1:0] addend;
  logic [DATA_W-1:0] acc_next;
  logic              load;

  // 3r^2 + 5r + 2 is the qubit index of column 0 on lattice row 3r+2
  assign base  = sq + DATA_W'({sq, 1'b0}) + DATA_W'({row, 2'b00}) + DATA_W'(row)
               + DATA_W'(2);
  assign two_c = DATA_W'({col, 1'b0});

  always_comb begin
    case (color)
      COLOR_DOWN: begin
        init_acc = base + two_c;
        init_cnt = CNT_W'({ROW_W'(nrows - row), 1'b0});
      end
      COLOR_LEFT: begin
        init_acc = base + two_c + DATA_W'(1);
        init_cnt = CNT_W'({ROW_W'(col + ROW_W'(1)), 1'b0});
      end
      default: begin
        // lattice row 3r+3 starts 2r+2 above row 3r+2
        init_acc = base + DATA_W'({row, 1'b0}) + DATA_W'(2) + two_c + DATA_W'(1);
        init_cnt = CNT_W'({ROW_W'(row - col + ROW_W'(1)), 1'b0});
      end
    endcase
  end

  always_comb begin
    case (color)
      COLOR_DOWN: begin
        if (phase) addend = DATA_W'({kk, 2'b00}) + DATA_W'(6);
        else       addend = DATA_W'({kk, 1'b0}) + DATA_W'(2);
      end
      COLOR_LEFT: addend = '1;
      default:    addend = DATA_W'(1);
    endcase
  end

  assign acc_next = acc + addend;
  assign load     = (state == P_EMIT) && (!out_valid || result.ready);

  assign status.idle        = (state == P_IDLE);
  assign result.valid       = out_valid;
  assign result.data_index  = out_data;
  assign result.last        = out_last;
  assign result.index_error = out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= P_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        out_data  <= acc;
        out_last  <= (remaining == CNT_W'(1));
        out_err   <= err_flag;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        P_IDLE: begin
          if (job.start) begin
            row   <= job.row;
            col   <= job.col;
            nrows <= job.nrows;
            color <= job.color;
            if (job.err) begin
              acc       <= '0;
              remaining <= CNT_W'(1);
              err_flag  <= 1'b1;
              state     <= P_EMIT;
            end else begin
              err_flag <= 1'b0;
              state    <= P_SQ;
            end
          end
        end
        P_SQ: begin
          sq    <= DATA_W'(row) * DATA_W'(row);
          state <= P_INIT;
        end
        P_INIT: begin
          acc       <= init_acc;
          remaining <= init_cnt;
          kk        <= row;
          phase     <= 1'b0;
          state     <= P_EMIT;
        end
        P_EMIT: begin
          if (load) begin
            acc       <= acc_next;
            remaining <= remaining - CNT_W'(1);
            phase     <= ~phase;
            if (phase) kk <= kk + ROW_W'(1);
            if (remaining == CNT_W'(1)) state <= P_IDLE;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  `CCBP_ASSERT(a_emit_count, (state == P_EMIT) |-> (remaining != '0), "emit with no result left")
  `CCBP_ASSERT_IMPL(a_err_result, out_valid && out_err, out_last && (out_data == '0), "bad flagged result")
  `CCBP_ASSERT_IMPL(a_job_idle, job.start, state == P_IDLE, "job while path busy")

endmodule

[rtl/color_code_boundary_path.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_code_boundary_path
// Boundary path generator for one check of a triangular color code lattice.
// ----------------------------------------------------------------------------
// A check request is first divided by 3, then its plaquette row is found by a
// serial triangular root search of one add and compare per cycle; the job
// handoff register, a squaring step and a setup step compute the first data
// qubit index, and the path goes out at one result per cycle, while the result
// side stays ready, from a single stepping adder: 2 to 64 results, or one
// flagged result when the check lies outside the lattice. Check ready stays
// low from acceptance until the last result is in the output register. The
// rows register acts as MAX_ROWS above it.
module color_code_boundary_path import ccbp_pkg::*; #(
  parameter int unsigned MAX_ROWS = 32
) (
  input  logic        clk,
  input  logic        rst,
  ccbp_cfg_if.sink    cfg,
  ccbp_in_if.sink     check,
  ccbp_out_if.source  result
);

  logic [CFG_W-1:0] rows_in_use;
  logic [ROW_W-1:0] nrows;
  path_status_t     path_status;
  job_t             job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      rows_in_use <= cfg.data;
    end
  end

  assign nrows = (rows_in_use > CFG_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : ROW_W'(rows_in_use);

  ccbp_root u_root (
    .clk         (clk),
    .rst         (rst),
    .nrows       (nrows),
    .path_status (path_status),
    .check       (check),
    .job         (job)
  );

  ccbp_path u_path (
    .clk    (clk),
    .rst    (rst),
    .job    (job),
    .status (path_status),
    .result (result)
  );

endmodule
